### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/spwm_pkg.sv
`timescale 1ns / 1ps
package spwm_pkg;

  localparam int CNT_W     = 8;
  localparam int IDX_W     = 12;
  localparam int LEN_W     = 13;
  localparam int DEAD_W    = 4;
  localparam int VAL_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int TABLE_DEPTH_DEF = 4096;

  // remainder unit: quotient of (idx + step) / len stays below 2**(MOD_K_MAX + 1)
  localparam int MOD_K_MAX = 11;
  localparam int MOD_K_W   = 4;
  localparam int MOD_SH_W  = LEN_W + MOD_K_MAX;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_PERIOD = 3'd0,
    CFG_PHASE_STEP     = 3'd1,
    CFG_TABLE_LENGTH   = 3'd2,
    CFG_B_START        = 3'd3,
    CFG_C_START        = 3'd4,
    CFG_DEAD_TICKS     = 3'd5
  } cfg_reg_t;

  localparam logic [CNT_W-1:0]  PERIOD_RST = 8'd100;
  localparam logic [IDX_W-1:0]  STEP_RST   = 12'd10;
  localparam logic [LEN_W-1:0]  LENGTH_RST = 13'd2100;
  localparam logic [IDX_W-1:0]  B_START_RST = 12'd700;
  localparam logic [IDX_W-1:0]  C_START_RST = 12'd1400;
  localparam logic [DEAD_W-1:0] DEAD_RST   = 4'd1;

  localparam logic [CNT_W-1:0] PERIOD_MIN = 8'd2;
  localparam logic [LEN_W-1:0] LEN_MIN    = 13'd3;
  localparam logic [LEN_W-1:0] LEN_MAX    = 13'd4096;

  // gate pair: {high, low}
  localparam logic [1:0] GATE_OFF  = 2'b00;
  localparam logic [1:0] GATE_LOW  = 2'b01;
  localparam logic [1:0] GATE_HIGH = 2'b10;
  localparam logic [1:0] GATE_BOTH = 2'b11;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_A    = 2'd0;
  localparam phase_t PH_LAST = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PHASE,
    S_MOD,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic in_valid;
    logic opcode;
    logic fast;
    logic mod_done;
    logic load_ok;
  } seq_in_t;

  typedef struct packed {
    logic in_ready;
    logic wr_en;
    logic rd_en;
    logic rd_home;
    logic gate_en;
    logic step_done;
    logic idx_from_mod;
    logic mod_start;
    logic cnt_en;
    logic out_load;
  } seq_ctl_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] value;
    logic [LEN_W-1:0] len;
  } mod_req_t;

endpackage

### rtl/spwm_table.sv
`timescale 1ns / 1ps
module spwm_table import spwm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = (AW > IDX_W) ? AW : IDX_W;

  logic [VAL_W-1:0] mem_r [TABLE_DEPTH];
  logic [VAL_W-1:0] data_r;
  logic             oob_r;
  logic [EW-1:0]    wr_ext;
  logic [EW-1:0]    rd_ext;
  logic             wr_in;
  logic             rd_in;

  assign wr_ext = EW'(wr_addr);
  assign rd_ext = EW'(rd_addr);
  assign wr_in  = 32'(wr_addr) < TABLE_DEPTH;
  assign rd_in  = 32'(rd_addr) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem_r[wr_ext[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= mem_r[rd_ext[AW-1:0]];
      oob_r  <= !rd_in;
    end
  end

  // entries past the array read as zero
  assign rd_data = oob_r ? '0 : data_r;

endmodule

### rtl/spwm_mod.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spwm_mod import spwm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mod_req_t         req,
  output logic [LEN_W-1:0] rem,
  output logic             done
);

  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [MOD_K_W-1:0] k_r;
  logic               run_r;
  logic [MOD_SH_W-1:0] dvs;
  logic [MOD_SH_W-1:0] remx;

  // one restoring step per cycle, high quotient bit first
  always_comb begin
    dvs  = MOD_SH_W'(len_r) << k_r;
    remx = MOD_SH_W'(rem_r);
    if (remx >= dvs) begin
      rem_nxt = LEN_W'(remx - dvs);
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (req.start) begin
      run_r <= 1'b1;
    end else if (run_r && k_r == '0) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.value;
      len_r <= req.len;
      k_r   <= MOD_K_W'(MOD_K_MAX);
    end else if (run_r) begin
      rem_r <= rem_nxt;
      k_r   <= k_r - MOD_K_W'(1);
    end
  end

  assign rem  = rem_r;
  assign done = !run_r;

  `ASSERT_CLK(a_rem_below_len, clk, rst_n, $fell(run_r) |-> (rem_r < len_r), "remainder not reduced")

endmodule

### rtl/spwm_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spwm_seq import spwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  seq_in_t  sin,
  output seq_ctl_t ctl
);

  seq_state_t state_r, state_nxt;
  phase_t     ph_r, ph_nxt;
  logic       adv_ok;
  logic       finish;
  logic       emit_done;
  logic       accept;
  logic       is_tick;
  seq_state_t after_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_A;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // control outputs
  always_comb begin
    ctl       = '0;
    adv_ok    = (ph_r != PH_LAST) || sin.load_ok;
    ctl.gate_en   = (state_r == S_PHASE) && (!sin.fast || adv_ok);
    ctl.mod_start = (state_r == S_PHASE) && !sin.fast;
    ctl.step_done = ((state_r == S_PHASE) && sin.fast && adv_ok) ||
                    ((state_r == S_MOD) && sin.mod_done && adv_ok);
    ctl.idx_from_mod = (state_r == S_MOD);
    finish    = ctl.step_done && (ph_r == PH_LAST);
    emit_done = (state_r == S_EMIT) && sin.load_ok;
    ctl.in_ready = (state_r == S_IDLE) || emit_done || finish;
    accept    = sin.in_valid && ctl.in_ready;
    is_tick   = (sin.opcode == OP_TICK);
    ctl.wr_en = accept && !is_tick;
    // phase slots rotate, so the next phase always sits in slot 1 mid-tick
    ctl.rd_home  = (state_r == S_IDLE) || (state_r == S_EMIT);
    ctl.rd_en    = (accept && is_tick) || (ctl.step_done && (ph_r != PH_LAST));
    ctl.cnt_en   = finish;
    ctl.out_load = finish || emit_done;
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    after_item = S_IDLE;
    if (accept) begin
      after_item = is_tick ? S_PHASE : S_EMIT;
    end
    if (ctl.step_done) begin
      ph_nxt = (ph_r == PH_LAST) ? PH_A : ph_r + phase_t'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        state_nxt = after_item;
      end
      S_PHASE: begin
        if (!sin.fast) begin
          state_nxt = S_MOD;
        end else if (finish) begin
          state_nxt = after_item;
        end
      end
      S_MOD: begin
        if (finish) begin
          state_nxt = after_item;
        end else if (ctl.step_done) begin
          state_nxt = S_PHASE;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_nxt = after_item;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_tick_starts_at_a, clk, rst_n, (accept && is_tick) |=> (state_r == S_PHASE && ph_r == PH_A), "tick did not start at phase a")
  `ASSERT_CLK(a_phase_moves_on_step, clk, rst_n, !$stable(ph_r) |-> $past(ctl.step_done), "phase moved without a finished step")

endmodule

### rtl/three_phase_sine_pwm_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Beat
// in_      input      in_valid / in_ready    opcode, table address, table value
// out_     output     out_valid / out_ready  six gate levels, carrier count
// cfg_     input      cfg_wr_en              register index, write data
//
// A tick works through the three phases in turn, with one read of the sine table's single read port each.
// A table write lands as its beat is taken. A phase index that lands at or beyond twice the table
// length (after a start or length change) goes through the remainder unit, which holds the phase step.
// Synchronous active-low reset; the table has no clearing pass and reads as unwritten.
// A result waits in the output register; with it full, the last phase step of a tick and
// the result of a table write hold, and a new input beat is taken only in the idle state.
`include "assert_macros.svh"
module three_phase_sine_pwm_unit import spwm_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [IDX_W-1:0]     in_table_addr,
  input  logic [VAL_W-1:0]     in_table_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_gate_a_high,
  output logic                 out_gate_a_low,
  output logic                 out_gate_b_high,
  output logic                 out_gate_b_low,
  output logic                 out_gate_c_high,
  output logic                 out_gate_c_low,
  output logic [CNT_W-1:0]     out_carrier_count,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [CNT_W-1:0]  carrier_period_r;
  logic [IDX_W-1:0]  phase_step_r;
  logic [LEN_W-1:0]  table_length_r;
  logic [DEAD_W-1:0] dead_ticks_r;

  // clamped settings, registered from the configuration registers
  logic [CNT_W-1:0] period_c_r, period_cl;
  logic [LEN_W-1:0] len_c_r, len_cl, lenm1;
  logic [IDX_W-1:0] step_c_r, step_cl;

  // phase slots, rotated after each phase step; slot 0 is the phase at work
  logic [IDX_W-1:0]  idx_r  [3];
  logic [IDX_W-1:0]  idx_nxt[3];
  logic              req_r  [3];
  logic              req_nxt[3];
  logic [DEAD_W-1:0] dead_r  [3];
  logic [DEAD_W-1:0] dead_nxt[3];
  logic [1:0]        gate_r  [3];
  logic [1:0]        gate_nxt[3];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W:0]    cnt_inc;

  logic              out_valid_r;
  logic [1:0]        out_gate_r[3];
  logic [CNT_W-1:0]  out_cnt_r;

  logic [VAL_W-1:0]  tbl;
  logic [IDX_W-1:0]  rd_addr;
  logic              req_calc;
  logic [DEAD_W-1:0] dead_base;
  logic [DEAD_W-1:0] dead_calc;
  logic [1:0]        gate_calc;
  logic              req0_new;
  logic [DEAD_W-1:0] dead0_new;
  logic [1:0]        gate0_new;
  logic [IDX_W-1:0]  idx0_new;
  logic [LEN_W-1:0]  sum;
  logic [LEN_W-1:0]  red1;
  logic              fast;
  logic              load_ok;

  seq_in_t           sin;
  seq_ctl_t          ctl;
  mod_req_t          mreq;
  logic [LEN_W-1:0]  mod_rem;
  logic              mod_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_period_r <= PERIOD_RST;
      phase_step_r     <= STEP_RST;
      table_length_r   <= LENGTH_RST;
      dead_ticks_r     <= DEAD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CARRIER_PERIOD: carrier_period_r <= cfg_data[CNT_W-1:0];
        CFG_PHASE_STEP:     phase_step_r     <= cfg_data[IDX_W-1:0];
        CFG_TABLE_LENGTH:   table_length_r   <= cfg_data[LEN_W-1:0];
        // start values only load the phase slots
        CFG_B_START, CFG_C_START: begin
        end
        CFG_DEAD_TICKS:     dead_ticks_r     <= cfg_data[DEAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    period_cl = (carrier_period_r < PERIOD_MIN) ? PERIOD_MIN : carrier_period_r;
    if (table_length_r < LEN_MIN) begin
      len_cl = LEN_MIN;
    end else if (table_length_r > LEN_MAX) begin
      len_cl = LEN_MAX;
    end else begin
      len_cl = table_length_r;
    end
    lenm1   = len_cl - LEN_W'(1);
    step_cl = ({1'b0, phase_step_r} > lenm1) ? lenm1[IDX_W-1:0] : phase_step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_c_r <= PERIOD_RST;
      len_c_r    <= LENGTH_RST;
      step_c_r   <= STEP_RST;
    end else begin
      period_c_r <= period_cl;
      len_c_r    <= len_cl;
      step_c_r   <= step_cl;
    end
  end

  assign load_ok = !out_valid_r || out_ready;

  assign sin.in_valid = in_valid;
  assign sin.opcode   = in_opcode;
  assign sin.fast     = fast;
  assign sin.mod_done = mod_done;
  assign sin.load_ok  = load_ok;

  spwm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sin   (sin),
    .ctl   (ctl)
  );

  assign rd_addr = ctl.rd_home ? idx_r[0] : idx_r[1];

  spwm_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (in_table_addr),
    .wr_data (in_table_value),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (tbl)
  );

  // one phase: compare, request, dead time
  always_comb begin
    if (cnt_r == '0) begin
      req_calc = 1'b1;
    end else if (cnt_r > tbl) begin
      req_calc = 1'b0;
    end else begin
      req_calc = req_r[0];
    end
    dead_base = (req_calc != req_r[0]) ? dead_ticks_r : dead_r[0];
    if (dead_base != '0) begin
      gate_calc = GATE_OFF;
      dead_calc = dead_base - DEAD_W'(1);
    end else begin
      gate_calc = req_calc ? GATE_HIGH : GATE_LOW;
      dead_calc = '0;
    end
  end

  // index advance: one subtract covers an index already below length
  always_comb begin
    sum  = {1'b0, idx_r[0]} + {1'b0, step_c_r};
    red1 = (sum >= len_c_r) ? sum - len_c_r : sum;
    fast = red1 < len_c_r;
  end

  assign mreq.start = ctl.mod_start;
  assign mreq.value = sum;
  assign mreq.len   = len_c_r;

  spwm_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rem   (mod_rem),
    .done  (mod_done)
  );

  always_comb begin
    req0_new  = ctl.gate_en ? req_calc  : req_r[0];
    dead0_new = ctl.gate_en ? dead_calc : dead_r[0];
    gate0_new = ctl.gate_en ? gate_calc : gate_r[0];
    idx0_new  = ctl.idx_from_mod ? mod_rem[IDX_W-1:0] : red1[IDX_W-1:0];

    for (int p = 0; p < 3; p++) begin
      idx_nxt[p]  = idx_r[p];
      req_nxt[p]  = req_r[p];
      dead_nxt[p] = dead_r[p];
      gate_nxt[p] = gate_r[p];
    end

    if (ctl.step_done) begin
      idx_nxt[0]  = idx_r[1];
      idx_nxt[1]  = idx_r[2];
      idx_nxt[2]  = idx0_new;
      req_nxt[0]  = req_r[1];
      req_nxt[1]  = req_r[2];
      req_nxt[2]  = req0_new;
      dead_nxt[0] = dead_r[1];
      dead_nxt[1] = dead_r[2];
      dead_nxt[2] = dead0_new;
      gate_nxt[0] = gate_r[1];
      gate_nxt[1] = gate_r[2];
      gate_nxt[2] = gate0_new;
    end else if (ctl.gate_en) begin
      req_nxt[0]  = req0_new;
      dead_nxt[0] = dead0_new;
      gate_nxt[0] = gate0_new;
    end

    // start writes reload their phase slot; they are to be written only when idle, which the block does not enforce
    if (cfg_wr_en && cfg_index == CFG_B_START) begin
      idx_nxt[1] = cfg_data[IDX_W-1:0];
    end
    if (cfg_wr_en && cfg_index == CFG_C_START) begin
      idx_nxt[2] = cfg_data[IDX_W-1:0];
    end
  end

  always_comb begin
    cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);
    if (!ctl.cnt_en) begin
      cnt_nxt = cnt_r;
    end else if (cnt_inc >= {1'b0, period_c_r}) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r[0] <= '0;
      idx_r[1] <= B_START_RST;
      idx_r[2] <= C_START_RST;
      for (int p = 0; p < 3; p++) begin
        req_r[p]  <= 1'b0;
        dead_r[p] <= '0;
        gate_r[p] <= GATE_OFF;
      end
      cnt_r <= '0;
    end else begin
      for (int p = 0; p < 3; p++) begin
        idx_r[p]  <= idx_nxt[p];
        req_r[p]  <= req_nxt[p];
        dead_r[p] <= dead_nxt[p];
        gate_r[p] <= gate_nxt[p];
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // slots are back in a, b, c order whenever a result is loaded
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int p = 0; p < 3; p++) begin
        out_gate_r[p] <= gate_nxt[p];
      end
      out_cnt_r <= cnt_nxt;
    end
  end

  assign in_ready          = ctl.in_ready;
  assign out_valid         = out_valid_r;
  assign out_gate_a_high   = out_gate_r[0][1];
  assign out_gate_a_low    = out_gate_r[0][0];
  assign out_gate_b_high   = out_gate_r[1][1];
  assign out_gate_b_low    = out_gate_r[1][0];
  assign out_gate_c_high   = out_gate_r[2][1];
  assign out_gate_c_low    = out_gate_r[2][0];
  assign out_carrier_count = out_cnt_r;

  `ASSERT_NEVER(a_no_shoot_through, clk, rst_n, (gate_r[0] == GATE_BOTH) || (gate_r[1] == GATE_BOTH) || (gate_r[2] == GATE_BOTH), "both gates of a phase on")

endmodule
